// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   `ASSERT_PROP(lbl, clk, rst, !(expr))

`endif

// ===== sv/rpmd_pkg.sv =====
// shared types, codes and constants of the rc pulse motor drive ramp
// no dependencies
package rpmd_pkg;

   localparam int TIMER_BITS       = 16;
   localparam int REVERSE_DWELL_MS = 100;
   localparam int DIV_W            = 23;
   localparam int DVS_W            = 16;
   localparam int CNT_W            = $clog2(DIV_W);

   localparam logic [11:0] RST_PULSE_MIN = 12'd1000;
   localparam logic [11:0] RST_PULSE_MAX = 12'd2000;
   localparam logic [11:0] RST_PULSE_MID = 12'd1500;
   localparam logic [9:0]  RST_DIR_BAND  = 10'd50;
   localparam logic [15:0] RST_RAMP_MS   = 16'd800;
   localparam logic [9:0]  RST_UPDATE_MS = 10'd15;
   localparam logic [15:0] RST_FAILSAFE  = 16'd200;
   localparam logic [6:0]  RST_MIN_RUN   = 7'd0;
   localparam logic [11:0] RST_FILTERED  = 12'd1000;

   typedef enum logic [1:0] {
      MODE_TICK = 2'd0,
      MODE_THR  = 2'd1,
      MODE_DIR  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      REG_PULSE_MIN = 3'd0,
      REG_PULSE_MAX = 3'd1,
      REG_PULSE_MID = 3'd2,
      REG_DIR_BAND  = 3'd3,
      REG_RAMP_MS   = 3'd4,
      REG_UPDATE_MS = 3'd5,
      REG_FAILSAFE  = 3'd6,
      REG_MIN_RUN   = 3'd7
   } reg_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_FAILSAFE = 3'd1,
      PH_REV_DOWN = 3'd2,
      PH_DWELL_A  = 3'd3,
      PH_DWELL_B  = 3'd4,
      PH_REV_UP   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_DIV  = 2'd1,
      ST_SEND = 2'd2
   } ctrl_type;

   typedef struct packed {
      logic exec;
      logic apply;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
   } stat_type;

   typedef struct packed {
      logic        busy_res;
      logic [11:0] smoothed_us;
      logic [6:0]  target_pct;
      logic        running;
      logic        dir_ccw;
      logic        enable_out;
      logic [7:0]  pwm_duty;
      logic [6:0]  drive_pct;
   } result_type;

   function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
      logic [TIMER_BITS-1:0] r;
      r = (v == '1) ? v : v + 1'b1;
      return r;
   endfunction

endpackage

// ===== sv/rc_pulse_motor_drive_ramp.sv =====
// an accepted item goes to ST_SEND, or first to ST_DIV when a map or ramp division runs
// next request taken only after the result transfer; divisions use the 23 bit serial divider
// one item in flight; configuration writes taken every cycle
// synchronous active high reset to reset values, divider data excepted; no clearing pass
// top level of the rc pulse motor drive ramp
// depends on rpmd_pkg, rpmd_ctrl, rpmd_dp
module rc_pulse_motor_drive_ramp (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // pulse_us
   input  logic [1:0]  req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // drive_pct, pwm_duty, enable_out, dir_ccw, running,
                                    // target_pct, smoothed_us, busy_res, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import rpmd_pkg::*;

   cmd_type    cmd;
   stat_type   stat;
   result_type result;

   assign csr_ready = 1'b1;

   rpmd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rpmd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_mode  (req_tuser),
      .req_pulse (req_tdata),
      .csr_we    (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .result    (result)
   );

   assign rsp_tdata = {2'b00, result};

endmodule

// ===== sv/rpmd_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on rpmd_pkg
module rpmd_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rpmd_pkg::DIV_W-1:0] dividend,
   input  logic [rpmd_pkg::DVS_W-1:0] divisor,
   output logic                       done,
   output logic [rpmd_pkg::DIV_W-1:0] quotient
);
   import rpmd_pkg::*;

   logic                 run_ff, run_in, done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DVS_W-1:0]     rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DVS_W:0]       rem_sh, rem_sub;
   logic                 ge;

   assign rem_sh  = {rem_ff, quo_ff[DIV_W-1]};
   assign ge      = rem_sh >= {1'b0, dvs_ff};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (run_ff) begin
         rem_in = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/rpmd_dp.sv =====
// datapath: configuration, drive state, filter, map and ramp arithmetic
// depends on rpmd_pkg and rpmd_div
module rpmd_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  rpmd_pkg::cmd_type    cmd,
   output rpmd_pkg::stat_type   stat,
   input  logic [1:0]           req_mode,
   input  logic [15:0]          req_pulse,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_data,
   output rpmd_pkg::result_type result
);
   import rpmd_pkg::*;

   logic [11:0] pmin_ff, pmax_ff, pmid_ff;
   logic [9:0]  band_ff, updms_ff;
   logic [15:0] rampms_ff, fsafe_ff;
   logic [6:0]  minrun_ff;

   logic [11:0]           fw_ff, fw_in;
   logic [6:0]            tgt_ff, tgt_in, drv_ff, drv_in, rs_ff, rs_in, re_ff, re_in;
   logic                  turn_ff, turn_in, on_ff, on_in, run_ff, run_in, want_ff, want_in;
   logic [TIMER_BITS-1:0] sil_ff, sil_in, upd_ff, upd_in, el_ff, el_in;
   phase_type             ph_ff, ph_in;
   logic                  kmap_ff, kmap_in;

   logic                  need_div, div_done;
   logic [DIV_W-1:0]      dvd, quo;
   logic [DVS_W-1:0]      dvs;

   logic [15:0] clamp_lo;
   logic [11:0] w;
   logic [13:0] fw_sum;
   logic [11:0] fw_new, numd, dend;
   logic [18:0] numabs;
   logic        num_neg, den_neg, map_zero, dir_hi, dir_lo, want_v;
   logic [6:0]  rdiff;
   logic [22:0] rprod;
   logic [6:0]  qpct, qlow;
   logic [14:0] x255;
   logic [27:0] dprod;

   assign clamp_lo = (req_pulse < {4'd0, pmin_ff}) ? {4'd0, pmin_ff} : req_pulse;
   assign w        = (clamp_lo > {4'd0, pmax_ff}) ? pmax_ff : clamp_lo[11:0];
   assign fw_sum   = {fw_ff, 1'b0} + {2'd0, fw_ff} + {2'd0, w};
   assign fw_new   = fw_sum[13:2];
   assign num_neg  = fw_new < pmin_ff;
   assign den_neg  = pmax_ff < pmin_ff;
   assign numd     = num_neg ? pmin_ff - fw_new : fw_new - pmin_ff;
   assign dend     = den_neg ? pmin_ff - pmax_ff : pmax_ff - pmin_ff;
   assign numabs   = 19'(numd) * 19'd100;
   assign map_zero = (dend == '0) || (numd == '0) || (num_neg != den_neg);
   assign dir_hi   = {1'b0, w} > ({1'b0, pmid_ff} + {3'd0, band_ff});
   assign dir_lo   = ({1'b0, w} + {3'd0, band_ff}) < {1'b0, pmid_ff};
   assign want_v   = dir_hi ? 1'b1 : (dir_lo ? 1'b0 : turn_ff);
   assign rdiff    = (re_ff >= rs_ff) ? re_ff - rs_ff : rs_ff - re_ff;
   assign rprod    = 23'(rdiff) * 23'(el_in);
   assign qlow     = (quo > 23'd127) ? 7'd127 : quo[6:0];
   assign qpct     = (quo < 23'(minrun_ff)) ? 7'd0 : ((quo > 23'd100) ? 7'd100 : qlow);

   always_comb begin
      fw_in    = fw_ff;
      tgt_in   = tgt_ff;
      drv_in   = drv_ff;
      rs_in    = rs_ff;
      re_in    = re_ff;
      turn_in  = turn_ff;
      on_in    = on_ff;
      run_in   = run_ff;
      want_in  = want_ff;
      sil_in   = sil_ff;
      upd_in   = upd_ff;
      el_in    = el_ff;
      ph_in    = ph_ff;
      kmap_in  = kmap_ff;
      need_div = 1'b0;
      dvd      = '0;
      dvs      = '0;
      if (cmd.exec) begin
         priority case (req_mode)
            MODE_TICK: begin
               sil_in = sat_inc(sil_ff);
               case (ph_ff)
                  PH_FAILSAFE, PH_REV_DOWN, PH_REV_UP: begin
                     el_in  = sat_inc(el_ff);
                     upd_in = sat_inc(upd_ff);
                     if (el_in >= rampms_ff) begin
                        drv_in = re_ff;
                        if (ph_ff == PH_FAILSAFE) begin
                           on_in  = 1'b0;
                           run_in = 1'b0;
                           ph_in  = PH_IDLE;
                        end else if (ph_ff == PH_REV_DOWN) begin
                           ph_in = PH_DWELL_A;
                           el_in = '0;
                        end else begin
                           run_in = 1'b1;
                           ph_in  = PH_IDLE;
                        end
                     end else if (upd_in >= TIMER_BITS'(updms_ff)) begin
                        upd_in   = '0;
                        need_div = 1'b1;
                        kmap_in  = 1'b0;
                        dvd      = rprod;
                        dvs      = rampms_ff;
                     end
                  end
                  PH_DWELL_A: begin
                     el_in = sat_inc(el_ff);
                     if (el_in >= TIMER_BITS'(REVERSE_DWELL_MS)) begin
                        turn_in = want_ff;
                        ph_in   = PH_DWELL_B;
                        el_in   = '0;
                     end
                  end
                  PH_DWELL_B: begin
                     el_in = sat_inc(el_ff);
                     if (el_in >= TIMER_BITS'(REVERSE_DWELL_MS)) begin
                        if (tgt_ff != '0) begin
                           on_in = 1'b1;
                           if (drv_ff == tgt_ff) begin
                              run_in = 1'b1;
                              ph_in  = PH_IDLE;
                           end else begin
                              ph_in  = PH_REV_UP;
                              rs_in  = drv_ff;
                              re_in  = tgt_ff;
                              el_in  = '0;
                              upd_in = '0;
                           end
                        end else begin
                           ph_in = PH_IDLE;
                        end
                     end
                  end
                  default: begin
                     ph_in  = PH_IDLE;
                     upd_in = sat_inc(upd_ff);
                     if (sil_in > fsafe_ff) begin
                        if (drv_ff != '0) begin
                           ph_in  = PH_FAILSAFE;
                           rs_in  = drv_ff;
                           re_in  = '0;
                           el_in  = '0;
                           upd_in = '0;
                        end else if (run_ff) begin
                           on_in  = 1'b0;
                           run_in = 1'b0;
                        end
                     end else if (upd_in >= TIMER_BITS'(updms_ff)) begin
                        upd_in = '0;
                        if (drv_ff < tgt_ff) begin
                           drv_in = drv_ff + 1'b1;
                           on_in  = 1'b1;
                           run_in = 1'b1;
                        end else if (drv_ff > tgt_ff) begin
                           drv_in = drv_ff - 1'b1;
                           if (drv_in == '0) begin
                              on_in  = 1'b0;
                              run_in = 1'b0;
                           end
                        end
                     end
                  end
               endcase
            end
            MODE_THR: begin
               if (ph_ff == PH_IDLE && req_pulse != '0) begin
                  fw_in  = fw_new;
                  sil_in = '0;
                  if (map_zero) begin
                     tgt_in = '0;
                  end else begin
                     need_div = 1'b1;
                     kmap_in  = 1'b1;
                     dvd      = 23'(numabs);
                     dvs      = 16'(dend);
                  end
               end
            end
            MODE_DIR: begin
               if (ph_ff == PH_IDLE && req_pulse != '0 && !(sil_ff > fsafe_ff)
                   && want_v != turn_ff) begin
                  want_in = want_v;
                  el_in   = '0;
                  if (drv_ff == '0) begin
                     ph_in = PH_DWELL_A;
                  end else begin
                     ph_in  = PH_REV_DOWN;
                     rs_in  = drv_ff;
                     re_in  = '0;
                     upd_in = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd.apply) begin
         if (kmap_ff) begin
            tgt_in = qpct;
         end else if (re_ff >= rs_ff) begin
            drv_in = rs_ff + quo[6:0];
         end else begin
            drv_in = rs_ff - quo[6:0];
         end
      end
   end

   rpmd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (need_div),
      .dividend (dvd),
      .divisor  (dvs),
      .done     (div_done),
      .quotient (quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pmin_ff   <= RST_PULSE_MIN;
         pmax_ff   <= RST_PULSE_MAX;
         pmid_ff   <= RST_PULSE_MID;
         band_ff   <= RST_DIR_BAND;
         rampms_ff <= RST_RAMP_MS;
         updms_ff  <= RST_UPDATE_MS;
         fsafe_ff  <= RST_FAILSAFE;
         minrun_ff <= RST_MIN_RUN;
      end else if (csr_we) begin
         unique case (reg_type'(csr_index))
            REG_PULSE_MIN: pmin_ff   <= csr_data[11:0];
            REG_PULSE_MAX: pmax_ff   <= csr_data[11:0];
            REG_PULSE_MID: pmid_ff   <= csr_data[11:0];
            REG_DIR_BAND:  band_ff   <= csr_data[9:0];
            REG_RAMP_MS:   rampms_ff <= csr_data;
            REG_UPDATE_MS: updms_ff  <= csr_data[9:0];
            REG_FAILSAFE:  fsafe_ff  <= csr_data;
            REG_MIN_RUN:   minrun_ff <= csr_data[6:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff   <= RST_FILTERED;
         tgt_ff  <= '0;
         drv_ff  <= '0;
         rs_ff   <= '0;
         re_ff   <= '0;
         turn_ff <= 1'b0;
         on_ff   <= 1'b1;
         run_ff  <= 1'b0;
         want_ff <= 1'b0;
         sil_ff  <= '0;
         upd_ff  <= '0;
         el_ff   <= '0;
         ph_ff   <= PH_IDLE;
         kmap_ff <= 1'b0;
      end else begin
         fw_ff   <= fw_in;
         tgt_ff  <= tgt_in;
         drv_ff  <= drv_in;
         rs_ff   <= rs_in;
         re_ff   <= re_in;
         turn_ff <= turn_in;
         on_ff   <= on_in;
         run_ff  <= run_in;
         want_ff <= want_in;
         sil_ff  <= sil_in;
         upd_ff  <= upd_in;
         el_ff   <= el_in;
         ph_ff   <= ph_in;
         kmap_ff <= kmap_in;
      end
   end

   // duty = drive*255/100 via reciprocal 5243/2^19
   assign x255  = {drv_ff, 8'd0} - {8'd0, drv_ff};
   assign dprod = 28'(x255) * 28'd5243;

   assign stat.need_div = need_div;
   assign stat.div_done = div_done;

   assign result.drive_pct   = drv_ff;
   assign result.pwm_duty    = dprod[26:19];
   assign result.enable_out  = on_ff;
   assign result.dir_ccw     = turn_ff;
   assign result.running     = run_ff;
   assign result.target_pct  = tgt_ff;
   assign result.smoothed_us = fw_ff;
   assign result.busy_res    = ph_ff != PH_IDLE;

endmodule

// ===== sv/rpmd_ctrl.sv =====
// controller: sequences accept, division and result transfer
// depends on rpmd_pkg
module rpmd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  rpmd_pkg::stat_type stat,
   output rpmd_pkg::cmd_type  cmd
);
   import rpmd_pkg::*;

   ctrl_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd.exec   = 1'b0;
      cmd.apply  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.exec = 1'b1;
               state_in = stat.need_div ? ST_DIV : ST_SEND;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               cmd.apply = 1'b1;
               state_in  = ST_SEND;
            end
         end
         ST_SEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== sv/rpmd_checker.sv =====
// port-level checker for the rc pulse motor drive ramp, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module rpmd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   `ASSERT_PROP(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `ASSERT_NEVER(a_one_side, clock, reset, req_tready && rsp_tvalid)
   `ASSERT_PROP(a_one_item, clock, reset, req_tvalid && req_tready |=> !req_tready)
   `ASSERT_PROP(a_drive_range, clock, reset, rsp_tvalid |-> rsp_tdata[6:0] <= 7'd100)

endmodule

bind rc_pulse_motor_drive_ramp rpmd_checker u_rpmd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
